/* design/pulse_saw_sound_channels_unit_defines.svh */
// Assertion macros for the pulse and saw sound channel unit.
`ifndef PULSE_SAW_SOUND_CHANNELS_UNIT_DEFINES_SVH
`define PULSE_SAW_SOUND_CHANNELS_UNIT_DEFINES_SVH
`ifndef SYNTH
`define PSC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("psc check failed");
`define PSC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("psc check failed");
`else
`define PSC_ASSERT(label, clk, rst, prop)
`define PSC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* design/psc_pkg.sv */
// Shared types and constants of the pulse and saw sound channel unit.
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int PERIOD_W      = 12;
  localparam int STEP_W        = 28;
  localparam int PHASE_W       =
    ((FRACTION_BITS + PERIOD_W > STEP_W) ? FRACTION_BITS + PERIOD_W : STEP_W) + 1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] CH_P1   = 2'd0;
  localparam logic [1:0] CH_P2   = 2'd1;
  localparam logic [1:0] CH_SAW  = 2'd2;

  localparam logic [1:0] REG_CTRL = 2'd0;
  localparam logic [1:0] REG_A    = 2'd1;
  localparam logic [1:0] REG_B    = 2'd2;

  localparam logic [1:0] CFG_PULSE_STEP = 2'd0;
  localparam logic [1:0] CFG_SAW_STEP   = 2'd1;
  localparam logic [1:0] CFG_LINE_SWAP  = 2'd2;
  localparam logic [1:0] CFG_MUTE_MASK  = 2'd3;

  localparam logic [2:0] SAW_LAST = 3'd6;

  typedef struct packed {
    logic       opcode;
    logic [1:0] channel;
    logic [1:0] reg_index;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pulse1_level;
    logic [3:0] pulse2_level;
    logic [4:0] saw_level;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0] pulse_phase_step;
    logic [STEP_W-1:0] saw_phase_step;
    logic              line_swap;
    logic [2:0]        mute_mask;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [1:0] channel;
    logic [1:0] reg_index;
    logic [7:0] value;
  } psc_wr_t;

  typedef struct packed {
    logic [7:0]          reg0;
    logic                enabled;
    logic [PERIOD_W-1:0] period;
  } psc_chan_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] channel;
  } psc_clr_t;

  typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;

  typedef struct packed {
    alu_op_t                    op;
    logic signed [PHASE_W-1:0] a;
    logic signed [PHASE_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic signed [PHASE_W-1:0] sum;
    logic                      neg;
  } alu_rsp_t;

endpackage
`default_nettype wire

/* design/psc_alu.sv */
// Shared phase adder and sign test.
`timescale 1ns / 1ps
`default_nettype none
module psc_alu import psc_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic signed [PHASE_W-1:0] sum;

  always_comb begin
    case (req.op)
      ALU_ADD: sum = req.a + req.b;
      ALU_SUB: sum = req.a - req.b;
      default: sum = req.a;
    endcase
  end

  assign rsp.sum = sum;
  assign rsp.neg = sum[PHASE_W-1];

endmodule
`default_nettype wire

/* design/psc_regs.sv */
// Channel register file, stored periods and enable-clear detection.
`timescale 1ns / 1ps
`default_nettype none
module psc_regs import psc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  psc_wr_t    wr,
  input  logic       line_swap,
  input  logic [1:0] rd_ch,
  output psc_chan_t  rd,
  output psc_clr_t   clr
);

  logic [7:0]          reg0   [3];
  logic [7:0]          reg1   [3];
  logic [7:0]          reg2   [3];
  logic [PERIOD_W-1:0] period [3];

  logic                wr_ok;
  logic [1:0]          hi_idx;
  logic [7:0]          old_hi;
  logic [7:0]          new1;
  logic [7:0]          new2;
  logic [PERIOD_W-1:0] period_next;

  assign wr_ok  = wr.en && (wr.channel != 2'd3);
  assign hi_idx = line_swap ? REG_B : REG_A;

  always_comb begin
    old_hi = 8'd0;
    new1   = 8'd0;
    new2   = 8'd0;
    if (wr_ok) begin
      old_hi = line_swap ? reg2[wr.channel] : reg1[wr.channel];
      new1   = (wr.reg_index == REG_A) ? wr.value : reg1[wr.channel];
      new2   = (wr.reg_index == REG_B) ? wr.value : reg2[wr.channel];
    end
    period_next = line_swap ? {new2[3:0], new1} : {new1[3:0], new2};
  end

  assign clr.hit     = wr_ok && (wr.reg_index == hi_idx) && old_hi[7] && !wr.value[7];
  assign clr.channel = wr.channel;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        reg0[i]   <= 8'd0;
        reg1[i]   <= 8'd0;
        reg2[i]   <= 8'd0;
        period[i] <= '0;
      end
    end else if (wr_ok) begin
      case (wr.reg_index)
        REG_CTRL: reg0[wr.channel] <= wr.value;
        REG_A:    reg1[wr.channel] <= wr.value;
        REG_B:    reg2[wr.channel] <= wr.value;
        default: ;
      endcase
      if (wr.reg_index inside {REG_A, REG_B}) begin
        period[wr.channel] <= period_next;
      end
    end
  end

  assign rd.reg0    = reg0[rd_ch];
  assign rd.enabled = line_swap ? reg2[rd_ch][7] : reg1[rd_ch][7];
  assign rd.period  = period[rd_ch];

endmodule
`default_nettype wire

/* design/psc_core.sv */
// Sample sequencer: phase catch-up loop, duty and saw positions, levels, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_saw_sound_channels_unit_defines.svh"
module psc_core import psc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cfg_t       cfg,
  input  psc_chan_t  chan,
  input  psc_clr_t   clr,
  output logic [1:0] rd_ch,
  output alu_req_t   alu_req,
  input  alu_rsp_t   alu_rsp,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SUB    = 5'b00010,
    S_ADD    = 5'b00100,
    S_LEVEL  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [1:0]                ch;
  logic signed [PHASE_W-1:0] phase [3];
  logic [3:0]                duty  [2];
  logic [2:0]                saw_pos;
  logic [8:0]                saw_acc;
  logic [3:0]                lvl_p1;
  logic [3:0]                lvl_p2;
  logic [4:0]                lvl_saw;

  logic                      running;
  logic [3:0]                pulse_lvl;
  logic                      out_load;
  logic [2:0]                phase_neg;

  assign running = (chan.period != '0) && !cfg.mute_mask[ch] && chan.enabled;
  assign rd_ch   = ch;
  assign busy    = (state != S_IDLE);

  assign phase_neg = {phase[2][PHASE_W-1], phase[1][PHASE_W-1], phase[0][PHASE_W-1]};

  assign pulse_lvl = (running && (chan.reg0[7] || (duty[ch[0]] > {1'b0, chan.reg0[6:4]})))
                     ? chan.reg0[3:0] : 4'd0;

  always_comb begin
    alu_req.a  = phase[ch];
    alu_req.op = ALU_SUB;
    alu_req.b  = PHASE_W'((ch == CH_SAW) ? cfg.saw_phase_step : cfg.pulse_phase_step);
    if (state == S_ADD) begin
      alu_req.op = ALU_ADD;
      alu_req.b  = PHASE_W'({chan.period, {FRACTION_BITS{1'b0}}});
    end
  end

  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_SUB;
      S_SUB: begin
        if (running && alu_rsp.neg) state_next = S_ADD;
        else state_next = S_LEVEL;
      end
      S_ADD:    if (!alu_rsp.neg) state_next = S_LEVEL;
      S_LEVEL:  state_next = (ch == CH_SAW) ? S_FINISH : S_SUB;
      S_FINISH: if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= CH_P1;
      out_valid <= 1'b0;
      saw_pos   <= 3'd0;
      saw_acc   <= 9'd0;
      for (int i = 0; i < 3; i++) phase[i] <= '0;
      for (int i = 0; i < 2; i++) duty[i] <= 4'd0;
    end else begin
      state <= state_next;
      if (clr.hit) begin
        if (clr.channel == CH_SAW) begin
          saw_pos <= 3'd0;
          saw_acc <= 9'd0;
        end else begin
          duty[clr.channel[0]] <= 4'd0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:   ch <= CH_P1;
        S_SUB:    if (running) phase[ch] <= alu_rsp.sum;
        S_ADD: begin
          phase[ch] <= alu_rsp.sum;
          if (ch == CH_SAW) begin
            if (saw_pos == SAW_LAST) begin
              saw_pos <= 3'd0;
              saw_acc <= 9'd0;
            end else begin
              saw_pos <= saw_pos + 3'd1;
              saw_acc <= saw_acc + {3'd0, chan.reg0[5:0]};
            end
          end else begin
            duty[ch[0]] <= duty[ch[0]] + 4'd1;
          end
        end
        S_LEVEL: begin
          case (ch)
            CH_P1:   lvl_p1  <= pulse_lvl;
            CH_P2:   lvl_p2  <= pulse_lvl;
            default: lvl_saw <= running ? saw_acc[7:3] : 5'd0;
          endcase
          if (ch != CH_SAW) ch <= ch + 2'd1;
        end
        S_FINISH: begin
          if (out_load) begin
            out_data.pulse1_level <= lvl_p1;
            out_data.pulse2_level <= lvl_p2;
            out_data.saw_level    <= lvl_saw;
          end
        end
        default: ;
      endcase
    end
  end

  `PSC_ASSERT(a_add_only_when_negative, clk, rst, (state == S_ADD) |-> phase[ch][PHASE_W-1])
  `PSC_ASSERT(a_idle_phases_nonneg, clk, rst, (state == S_IDLE) |-> (phase_neg == 3'd0))
  `PSC_ASSERT(a_saw_pos_range, clk, rst, saw_pos != 3'd7)
  `PSC_ASSERT(a_finish_after_saw, clk, rst, (state == S_FINISH) |-> (ch == CH_SAW))
  `PSC_ASSERT_ALWAYS(a_reset_to_idle, clk, rst |=> (state == S_IDLE && !out_valid))

endmodule
`default_nettype wire

/* design/pulse_saw_sound_channels_unit.sv */
// Top level of the two-pulse, one-saw sound channel unit.
// A write item (opcode 0) updates one channel register and gives no result.
// A sample item (opcode 1) gives one result: each running channel subtracts
// its phase step and adds its period back until the phase is no longer
// negative, and each channel forms its level, all through a single shared
// phase adder; the output register is then loaded, which waits while the
// output is stalled. Input stall stays high while a sample is in work. A
// finished result sits in the output register while new items are taken.
// Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none
module pulse_saw_sound_channels_unit import psc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [STEP_W-1:0] cfg_data
);

  cfg_t       cfg;
  psc_wr_t    wr;
  psc_chan_t  chan;
  psc_clr_t   clr;
  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;
  logic [1:0] rd_ch;
  logic       busy;
  logic       in_accept;
  logic       start;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign start     = in_accept && (in_data.opcode == OP_SAMPLE);

  assign wr.en        = in_accept && (in_data.opcode == OP_WRITE);
  assign wr.channel   = in_data.channel;
  assign wr.reg_index = in_data.reg_index;
  assign wr.value     = in_data.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PULSE_STEP: cfg.pulse_phase_step <= cfg_data;
        CFG_SAW_STEP:   cfg.saw_phase_step   <= cfg_data;
        CFG_LINE_SWAP:  cfg.line_swap        <= cfg_data[0];
        CFG_MUTE_MASK:  cfg.mute_mask        <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  psc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .line_swap (cfg.line_swap),
    .rd_ch     (rd_ch),
    .rd        (chan),
    .clr       (clr)
  );

  psc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  psc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg       (cfg),
    .chan      (chan),
    .clr       (clr),
    .rd_ch     (rd_ch),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
